/* src/tcs_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tcs_pkg: shared definitions for the text character statistics block
// Operation codes of the shared unit, histogram control bundle, character
// constants and record kinds.
// ----------------------------------------------------------------------------
package tcs_pkg;

    localparam int HIST_DEPTH = 52;
    localparam int HIST_AW    = 6;
    localparam int ALPHA_SIZE = 26;

    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
    localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
    localparam logic [7:0] LINE_END     = 8'd10;

    localparam logic [29:0] SHORT_INIT_VAL = 30'd999999999;

    localparam logic REQ_CHAR = 1'b0;
    localparam logic REQ_END  = 1'b1;

    localparam logic [1:0] KIND_SUMMARY = 2'd0;
    localparam logic [1:0] KIND_CAPITAL = 2'd1;
    localparam logic [1:0] KIND_LOWER   = 2'd2;

    typedef enum logic [1:0] {
        ALU_INC,
        ALU_GT,
        ALU_LT
    } alu_op_t;

    typedef struct packed {
        logic               rd_en;
        logic [HIST_AW-1:0] rd_addr;
        logic               wr_en;
        logic [HIST_AW-1:0] wr_addr;
        logic               clear;
    } hist_ctl_t;

endpackage
`default_nettype wire

/* src/text_character_statistics.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// text_character_statistics: character class histogram and line statistics
// Input beats carry one text byte (req_type 0) or an end-of-stream marker
// (req_type 1). A byte beat produces no output; it is accepted when in_valid
// is high and in_stall low, then the block holds in_stall high while one
// shared incrementer/comparator updates the class counter, the line length
// or line count, the longest and shortest line and, for letters, the
// histogram bin (read, then written back).
// An end-of-stream beat yields 53 output beats: one summary record, then 52
// histogram beats (capitals A to Z, lowercase a to z), the last flagged by
// last_record. The final line is compared with the longest and shortest
// line before the summary; each bin beat is a memory read, then an output load.
// A stall on the output holds the current beat and pauses the sequence.
// After the last beat all statistics return to their reset values.
// Reset clears every counter and histogram bin at once; the block is ready
// as soon as reset is released.
// ----------------------------------------------------------------------------
module text_character_statistics #(
    parameter int COUNT_WIDTH = 32
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         in_valid,
    output logic        in_stall,
    input  wire         req_type,
    input  wire [7:0]   char_code,
    output logic        out_valid,
    input  wire         out_stall,
    output logic [1:0]  record_kind,
    output logic [4:0]  letter_index,
    output logic [31:0] bin_count,
    output logic [31:0] capital_total,
    output logic [31:0] lowercase_total,
    output logic [31:0] digit_total,
    output logic [31:0] other_total,
    output logic [31:0] line_total,
    output logic [31:0] longest_line,
    output logic [29:0] shortest_line,
    output logic        last_record
);

    localparam int CW = COUNT_WIDTH;
    localparam logic [CW-1:0] SHORT_INIT =
        (CW >= 30) ? CW'(tcs_pkg::SHORT_INIT_VAL) : {CW{1'b1}};
    localparam logic [tcs_pkg::HIST_AW-1:0] LAST_BIN =
        tcs_pkg::HIST_AW'(tcs_pkg::HIST_DEPTH - 1);
    localparam logic [tcs_pkg::HIST_AW-1:0] ALPHA =
        tcs_pkg::HIST_AW'(tcs_pkg::ALPHA_SIZE);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLASS,
        ST_LEN,
        ST_LONG,
        ST_SHORT,
        ST_BIN,
        ST_R_LONG,
        ST_R_SHORT,
        ST_R_SUM,
        ST_R_READ,
        ST_R_BIN
    } state_t;

    typedef enum logic [2:0] {
        CLS_CAP,
        CLS_LOW,
        CLS_DIG,
        CLS_OTH,
        CLS_NL
    } cls_t;

    state_t                         state_reg;
    cls_t                           cls_reg;
    cls_t                           cls_next;
    logic [tcs_pkg::HIST_AW-1:0]    bin_addr_reg;
    logic [tcs_pkg::HIST_AW-1:0]    bin_addr_next;
    logic [tcs_pkg::HIST_AW-1:0]    bin_k_reg;

    logic [CW-1:0] cap_reg;
    logic [CW-1:0] low_reg;
    logic [CW-1:0] dig_reg;
    logic [CW-1:0] oth_reg;
    logic [CW-1:0] line_reg;
    logic [CW-1:0] longest_reg;
    logic [CW-1:0] shortest_reg;
    logic [CW-1:0] len_reg;

    logic        out_valid_reg;
    logic [1:0]  kind_reg;
    logic [4:0]  index_reg;
    logic [31:0] bin_reg;
    logic [31:0] cap_out_reg;
    logic [31:0] low_out_reg;
    logic [31:0] dig_out_reg;
    logic [31:0] oth_out_reg;
    logic [31:0] line_out_reg;
    logic [31:0] longest_out_reg;
    logic [29:0] shortest_out_reg;
    logic        last_reg;

    tcs_pkg::alu_op_t   alu_op;
    logic [CW-1:0]      alu_a;
    logic [CW-1:0]      alu_b;
    logic [CW-1:0]      alu_result;
    logic               alu_flag;

    tcs_pkg::hist_ctl_t hist_ctl;
    logic [CW-1:0]      hist_rd_data;

    logic in_take;
    logic out_free;
    logic out_load;

    assign in_stall = (state_reg != ST_IDLE);
    assign in_take  = in_valid && (state_reg == ST_IDLE);
    assign out_free = !out_valid_reg || !out_stall;
    assign out_load = out_free && ((state_reg == ST_R_SUM) || (state_reg == ST_R_BIN));

    // Byte classification and histogram address.
    always_comb
    begin
        bin_addr_next = '0;
        if ((char_code >= tcs_pkg::CHAR_UPPER_A) && (char_code <= tcs_pkg::CHAR_UPPER_Z))
        begin
            cls_next      = CLS_CAP;
            bin_addr_next = tcs_pkg::HIST_AW'(char_code - tcs_pkg::CHAR_UPPER_A);
        end
        else if ((char_code >= tcs_pkg::CHAR_LOWER_A) && (char_code <= tcs_pkg::CHAR_LOWER_Z))
        begin
            cls_next      = CLS_LOW;
            bin_addr_next = tcs_pkg::HIST_AW'(char_code - tcs_pkg::CHAR_LOWER_A) + ALPHA;
        end
        else if ((char_code >= tcs_pkg::CHAR_DIGIT_0) && (char_code <= tcs_pkg::CHAR_DIGIT_9))
        begin
            cls_next = CLS_DIG;
        end
        else if (char_code == tcs_pkg::LINE_END)
        begin
            cls_next = CLS_NL;
        end
        else
        begin
            cls_next = CLS_OTH;
        end
    end

    // Operand selection for the shared unit.
    always_comb
    begin
        alu_op = tcs_pkg::ALU_INC;
        alu_a  = len_reg;
        alu_b  = longest_reg;
        unique case (state_reg)
            ST_CLASS:
            begin
                case (cls_reg)
                    CLS_CAP: alu_a = cap_reg;
                    CLS_LOW: alu_a = low_reg;
                    CLS_DIG: alu_a = dig_reg;
                    default: alu_a = oth_reg;
                endcase
            end
            ST_LEN:
            begin
                alu_a = (cls_reg == CLS_NL) ? line_reg : len_reg;
            end
            ST_LONG, ST_R_LONG:
            begin
                alu_op = tcs_pkg::ALU_GT;
                alu_b  = longest_reg;
            end
            ST_SHORT, ST_R_SHORT:
            begin
                alu_op = tcs_pkg::ALU_LT;
                alu_b  = shortest_reg;
            end
            ST_BIN:
            begin
                alu_a = hist_rd_data;
            end
            default:
            begin
                alu_op = tcs_pkg::ALU_INC;
                alu_a  = len_reg;
            end
        endcase
    end

    always_comb
    begin
        hist_ctl         = '0;
        hist_ctl.wr_addr = bin_addr_reg;
        hist_ctl.rd_addr = bin_addr_next;
        if (in_take && (req_type == tcs_pkg::REQ_CHAR) &&
            ((cls_next == CLS_CAP) || (cls_next == CLS_LOW)))
        begin
            hist_ctl.rd_en = 1'b1;
        end
        if (state_reg == ST_R_READ)
        begin
            hist_ctl.rd_en   = 1'b1;
            hist_ctl.rd_addr = bin_k_reg;
        end
        if (state_reg == ST_BIN)
        begin
            hist_ctl.wr_en = 1'b1;
        end
        if ((state_reg == ST_R_BIN) && out_free && (bin_k_reg == LAST_BIN))
        begin
            hist_ctl.clear = 1'b1;
        end
    end

    tcs_alu #(
        .COUNT_WIDTH (CW)
    ) u_alu (
        .op     (alu_op),
        .a      (alu_a),
        .b      (alu_b),
        .result (alu_result),
        .flag   (alu_flag)
    );

    tcs_hist #(
        .COUNT_WIDTH (CW)
    ) u_hist (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (hist_ctl),
        .wr_data (alu_result),
        .rd_data (hist_rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cls_reg       <= CLS_OTH;
            bin_addr_reg  <= '0;
            bin_k_reg     <= '0;
            cap_reg       <= '0;
            low_reg       <= '0;
            dig_reg       <= '0;
            oth_reg       <= '0;
            line_reg      <= CW'(1);
            longest_reg   <= '0;
            shortest_reg  <= SHORT_INIT;
            len_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!out_stall && !out_load)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        cls_reg      <= cls_next;
                        bin_addr_reg <= bin_addr_next;
                        state_reg    <= (req_type == tcs_pkg::REQ_END) ? ST_R_LONG : ST_CLASS;
                    end
                end
                ST_CLASS:
                begin
                    case (cls_reg)
                        CLS_CAP: cap_reg <= alu_result;
                        CLS_LOW: low_reg <= alu_result;
                        CLS_DIG: dig_reg <= alu_result;
                        default: oth_reg <= alu_result;
                    endcase
                    state_reg <= ST_LEN;
                end
                ST_LEN:
                begin
                    if (cls_reg == CLS_NL)
                    begin
                        line_reg  <= alu_result;
                        state_reg <= ST_LONG;
                    end
                    else
                    begin
                        len_reg <= alu_result;
                        if ((cls_reg == CLS_CAP) || (cls_reg == CLS_LOW))
                        begin
                            state_reg <= ST_BIN;
                        end
                        else
                        begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                ST_LONG:
                begin
                    if (alu_flag)
                    begin
                        longest_reg <= len_reg;
                    end
                    state_reg <= ST_SHORT;
                end
                ST_SHORT:
                begin
                    if (alu_flag)
                    begin
                        shortest_reg <= len_reg;
                    end
                    len_reg   <= '0;
                    state_reg <= ST_IDLE;
                end
                ST_BIN:
                begin
                    state_reg <= ST_IDLE;
                end
                ST_R_LONG:
                begin
                    // The final line takes part even when it is empty.
                    if (alu_flag)
                    begin
                        longest_reg <= len_reg;
                    end
                    state_reg <= ST_R_SHORT;
                end
                ST_R_SHORT:
                begin
                    if (alu_flag)
                    begin
                        shortest_reg <= len_reg;
                    end
                    state_reg <= ST_R_SUM;
                end
                ST_R_SUM:
                begin
                    if (out_free)
                    begin
                        out_valid_reg    <= 1'b1;
                        kind_reg         <= tcs_pkg::KIND_SUMMARY;
                        index_reg        <= '0;
                        bin_reg          <= '0;
                        cap_out_reg      <= 32'(cap_reg);
                        low_out_reg      <= 32'(low_reg);
                        dig_out_reg      <= 32'(dig_reg);
                        oth_out_reg      <= 32'(oth_reg);
                        line_out_reg     <= 32'(line_reg);
                        longest_out_reg  <= 32'(longest_reg);
                        shortest_out_reg <= 30'(shortest_reg);
                        last_reg         <= 1'b0;
                        bin_k_reg        <= '0;
                        state_reg        <= ST_R_READ;
                    end
                end
                ST_R_READ:
                begin
                    state_reg <= ST_R_BIN;
                end
                ST_R_BIN:
                begin
                    if (out_free)
                    begin
                        out_valid_reg    <= 1'b1;
                        if (bin_k_reg < ALPHA)
                        begin
                            kind_reg  <= tcs_pkg::KIND_CAPITAL;
                            index_reg <= 5'(bin_k_reg);
                        end
                        else
                        begin
                            kind_reg  <= tcs_pkg::KIND_LOWER;
                            index_reg <= 5'(bin_k_reg - ALPHA);
                        end
                        bin_reg          <= 32'(hist_rd_data);
                        cap_out_reg      <= '0;
                        low_out_reg      <= '0;
                        dig_out_reg      <= '0;
                        oth_out_reg      <= '0;
                        line_out_reg     <= '0;
                        longest_out_reg  <= '0;
                        shortest_out_reg <= '0;
                        last_reg         <= (bin_k_reg == LAST_BIN);
                        if (bin_k_reg == LAST_BIN)
                        begin
                            // Report done: return every statistic to its reset value.
                            cap_reg      <= '0;
                            low_reg      <= '0;
                            dig_reg      <= '0;
                            oth_reg      <= '0;
                            line_reg     <= CW'(1);
                            longest_reg  <= '0;
                            shortest_reg <= SHORT_INIT;
                            len_reg      <= '0;
                            state_reg    <= ST_IDLE;
                        end
                        else
                        begin
                            bin_k_reg <= bin_k_reg + tcs_pkg::HIST_AW'(1);
                            state_reg <= ST_R_READ;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid       = out_valid_reg;
    assign record_kind     = kind_reg;
    assign letter_index    = index_reg;
    assign bin_count       = bin_reg;
    assign capital_total   = cap_out_reg;
    assign lowercase_total = low_out_reg;
    assign digit_total     = dig_out_reg;
    assign other_total     = oth_out_reg;
    assign line_total      = line_out_reg;
    assign longest_line    = longest_out_reg;
    assign shortest_line   = shortest_out_reg;
    assign last_record     = last_reg;

endmodule
`default_nettype wire

/* src/tcs_alu.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tcs_alu: shared saturating incrementer and magnitude comparator
// Every statistic update and line length comparison goes through here.
// ----------------------------------------------------------------------------
module tcs_alu #(
    parameter int COUNT_WIDTH = 32
) (
    input  wire tcs_pkg::alu_op_t       op,
    input  wire [COUNT_WIDTH-1:0]       a,
    input  wire [COUNT_WIDTH-1:0]       b,
    output logic [COUNT_WIDTH-1:0]      result,
    output logic                        flag
);

    always_comb
    begin
        result = a;
        flag   = 1'b0;
        unique case (op)
            tcs_pkg::ALU_INC:
            begin
                // The counter holds once it reaches all ones.
                if (a != {COUNT_WIDTH{1'b1}})
                begin
                    result = a + COUNT_WIDTH'(1);
                end
            end
            tcs_pkg::ALU_GT: flag = (a > b);
            tcs_pkg::ALU_LT: flag = (a < b);
            default:
            begin
                result = a;
                flag   = 1'b0;
            end
        endcase
    end

endmodule
`default_nettype wire

/* src/tcs_hist.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tcs_hist: letter histogram store
// One write and one registered read per cycle. Per-entry valid bits make a
// cleared entry read as zero without sweeping the array.
// ----------------------------------------------------------------------------
module tcs_hist #(
    parameter int COUNT_WIDTH = 32
) (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire tcs_pkg::hist_ctl_t ctl,
    input  wire [COUNT_WIDTH-1:0]   wr_data,
    output logic [COUNT_WIDTH-1:0]  rd_data
);

    logic [COUNT_WIDTH-1:0]          mem [tcs_pkg::HIST_DEPTH];
    logic [tcs_pkg::HIST_DEPTH-1:0]  valid_reg;
    logic [COUNT_WIDTH-1:0]          rd_data_reg;
    logic                            rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[ctl.wr_addr] <= wr_data;
        end
        if (ctl.rd_en)
        begin
            rd_data_reg <= mem[ctl.rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.rd_en)
            begin
                rd_valid_reg <= valid_reg[ctl.rd_addr];
            end
            if (ctl.clear)
            begin
                valid_reg <= '0;
            end
            else if (ctl.wr_en)
            begin
                valid_reg[ctl.wr_addr] <= 1'b1;
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule
`default_nettype wire
